FILE: rtl/cbfs_pkg.sv
// Shared types and constants for the centre-band focus sharpness block.
`timescale 1ns / 1ps

package cbfs_pkg;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Pixel layout (RGB565, green in bits 10..5)
  localparam int PIX_W     = 16;
  localparam int GREEN_LSB = 5;
  localparam int GREEN_W   = 6;

  // Window bounds: columns w/8 .. w-w/8, rows h*5/16 .. h*11/16
  localparam int X_SHIFT  = 3;
  localparam int Y_SHIFT  = 4;
  localparam int Y0_MUL   = 5;
  localparam int Y1_MUL   = 11;

  // Result scaling
  localparam int SCALE_W = 10;
  localparam logic [SCALE_W-1:0] SCALE = 10'd1000;
  localparam int RES_W   = 16;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

endpackage

FILE: rtl/cbfs_fifo.sv
// Small register queue carrying per-frame gradient totals from front to back.
`timescale 1ns / 1ps

module cbfs_fifo #(
  parameter int DATA_W = 54,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/cbfs_front.sv
// Pixel front end: position counters, window test and gradient accumulation.
`timescale 1ns / 1ps

module cbfs_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [cbfs_pkg::CFG_W-1:0]             frame_width,
  input  logic [cbfs_pkg::CFG_W-1:0]             frame_height,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [cbfs_pkg::PIX_W-1:0]             in_tdata,
  input  logic                                   in_tuser,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [2*$clog2(MAX_DIMENSION)+5:0]     q_sum,
  output logic [2*$clog2(MAX_DIMENSION)-1:0]     q_pairs
);

  localparam int DIM_W = $clog2(MAX_DIMENSION);
  localparam int EW    = DIM_W + 1;
  localparam int SW    = 2 * DIM_W + cbfs_pkg::GREEN_W;
  localparam int PCW   = 2 * DIM_W;
  localparam int CW    = cbfs_pkg::CFG_W;
  localparam int WW    = (CW > EW) ? CW : EW;
  localparam int GW    = cbfs_pkg::GREEN_W;

  logic [DIM_W-1:0] col_r, col_nxt, col_eff;
  logic [DIM_W-1:0] row_r, row_nxt, row_eff;
  logic [SW-1:0]    sum_r, sum_nxt, sum_eff, sum_new;
  logic [PCW-1:0]   pairs_r, pairs_nxt, pairs_eff, pairs_new;
  logic [GW-1:0]    prev_g_r, prev_g_nxt;

  logic [EW-1:0]    w_eff, h_eff, x0, x1, y0, y1, w_last, h_last;
  logic [EW+2:0]    h5;
  logic [EW+3:0]    h11;
  logic [GW-1:0]    g, diff;
  logic [EW-1:0]    col_x, row_x;
  logic             in_win, last_col, frame_end, accept;

  // Clamp register values into 1..MAX_DIMENSION
  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW'(1);
    end else if (WW'(frame_width) > WW'(MAX_DIMENSION)) begin
      w_eff = EW'(MAX_DIMENSION);
    end else begin
      w_eff = EW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EW'(1);
    end else if (WW'(frame_height) > WW'(MAX_DIMENSION)) begin
      h_eff = EW'(MAX_DIMENSION);
    end else begin
      h_eff = EW'(frame_height);
    end
  end

  assign x0     = w_eff >> cbfs_pkg::X_SHIFT;
  assign x1     = w_eff - x0;
  assign h5     = (EW+3)'(h_eff) * (EW+3)'(cbfs_pkg::Y0_MUL);
  assign h11    = (EW+4)'(h_eff) * (EW+4)'(cbfs_pkg::Y1_MUL);
  assign y0     = EW'(h5 >> cbfs_pkg::Y_SHIFT);
  assign y1     = EW'(h11 >> cbfs_pkg::Y_SHIFT);
  assign w_last = w_eff - 1'b1;
  assign h_last = h_eff - 1'b1;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !q_full;
  assign g         = in_tdata[cbfs_pkg::GREEN_LSB +: GW];

  // Start of frame clears position and totals before this pixel is used
  assign col_eff   = in_tuser ? '0 : col_r;
  assign row_eff   = in_tuser ? '0 : row_r;
  assign sum_eff   = in_tuser ? '0 : sum_r;
  assign pairs_eff = in_tuser ? '0 : pairs_r;

  assign col_x  = EW'(col_eff);
  assign row_x  = EW'(row_eff);
  assign in_win = (row_x >= y0) && (row_x < y1) && (col_x > x0) && (col_x < x1);
  assign diff   = (g >= prev_g_r) ? (g - prev_g_r) : (prev_g_r - g);

  assign sum_new   = in_win ? (sum_eff + SW'(diff)) : sum_eff;
  assign pairs_new = in_win ? (pairs_eff + 1'b1) : pairs_eff;

  assign last_col  = (col_x >= w_last);
  assign frame_end = last_col && (row_x >= h_last);

  assign q_push  = accept && frame_end;
  assign q_sum   = sum_new;
  assign q_pairs = pairs_new;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    sum_nxt    = sum_r;
    pairs_nxt  = pairs_r;
    prev_g_nxt = prev_g_r;
    if (accept) begin
      prev_g_nxt = g;
      if (frame_end) begin
        col_nxt   = '0;
        row_nxt   = '0;
        sum_nxt   = '0;
        pairs_nxt = '0;
      end else begin
        sum_nxt   = sum_new;
        pairs_nxt = pairs_new;
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_eff + 1'b1;
        end else begin
          col_nxt = col_eff + 1'b1;
          row_nxt = row_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      sum_r    <= '0;
      pairs_r  <= '0;
      prev_g_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      sum_r    <= sum_nxt;
      pairs_r  <= pairs_nxt;
      prev_g_r <= prev_g_nxt;
    end
  end

endmodule

FILE: rtl/cbfs_back.sv
// Back end: scale by 1000, bit-serial divide by pair count, output register.
`timescale 1ns / 1ps

module cbfs_back #(
  parameter int SW  = 30,
  parameter int PCW = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [SW+PCW-1:0]             q_rdata,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cbfs_pkg::RES_W-1:0]    out_tdata
);

  localparam int NW   = SW + cbfs_pkg::SCALE_W;
  localparam int IT_W = $clog2(NW + 1);
  localparam int RW   = cbfs_pkg::RES_W;

  cbfs_pkg::bk_state_t state_r, state_nxt;

  logic [NW-1:0]   num_r, num_nxt;
  logic [PCW-1:0]  den_r, den_nxt;
  logic [PCW-1:0]  rem_r, rem_nxt;
  logic [IT_W-1:0] iter_r, iter_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [RW-1:0]   out_data_r, out_data_nxt;

  logic [PCW:0]    rem_sh;
  logic            q_bit, out_load;
  logic [RW-1:0]   quot_clamped;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbfs_pkg::BK_IDLE: begin
        if (!q_empty) state_nxt = cbfs_pkg::BK_MUL;
      end
      cbfs_pkg::BK_MUL: begin
        state_nxt = (den_r == '0) ? cbfs_pkg::BK_HOLD : cbfs_pkg::BK_DIV;
      end
      cbfs_pkg::BK_DIV: begin
        if (iter_r == IT_W'(1)) state_nxt = cbfs_pkg::BK_HOLD;
      end
      cbfs_pkg::BK_HOLD: begin
        if (!out_valid_r || out_tready) state_nxt = cbfs_pkg::BK_IDLE;
      end
      default: state_nxt = cbfs_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      cbfs_pkg::BK_IDLE: q_pop    = !q_empty;
      cbfs_pkg::BK_HOLD: out_load = !out_valid_r || out_tready;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Restoring divide step: quotient bits shift into num_r from the bottom
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  assign quot_clamped = (|num_r[NW-1:RW]) ? '1 : num_r[RW-1:0];

  always_comb begin
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      cbfs_pkg::BK_IDLE: begin
        if (q_pop) begin
          num_nxt = NW'(q_rdata[SW-1:0]);
          den_nxt = q_rdata[SW +: PCW];
        end
      end
      cbfs_pkg::BK_MUL: begin
        rem_nxt  = '0;
        iter_nxt = IT_W'(NW);
        if (den_r == '0) begin
          num_nxt = '0;
        end else begin
          num_nxt = NW'(num_r[SW-1:0]) * NW'(cbfs_pkg::SCALE);
        end
      end
      cbfs_pkg::BK_DIV: begin
        iter_nxt = iter_r - 1'b1;
        num_nxt  = {num_r[NW-2:0], q_bit};
        rem_nxt  = q_bit ? PCW'(rem_sh - {1'b0, den_r}) : rem_sh[PCW-1:0];
      end
      cbfs_pkg::BK_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = quot_clamped;
        end
      end
      default: begin
        num_nxt = num_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbfs_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/centre_band_focus_sharpness.sv
// Top level of the centre-band focus sharpness block (mean absolute green gradient).
`timescale 1ns / 1ps

// Channel  | Direction | Payload                              | Handshake
// ---------+-----------+--------------------------------------+-------------------------
// in_      | slave     | tdata: pixel[15:0]; tuser: sof       | tvalid & tready
// out_     | master    | tdata: sharpness[15:0]               | tvalid & tready
// cfg_     | write     | index 0 frame_width, 1 frame_height  | wr_en, no wait
//
// Pixels are taken one per clock. The front end stalls only while the two-entry
// totals queue is full, that is while the back end is still scaling, dividing or
// holding the result of an earlier frame.
// A frame's totals pass through the queue to the back end, which steps through idle,
// scale, divide and hold states; a frame with no pairs skips the divide. The divider
// produces one quotient bit per cycle, and the hold state loads the output register.
// Reset (synchronous, active low) clears counters, totals, queue, back-end state and
// output valid and loads 1920 x 1080; no clearing pass is needed.
// A stalled result holds in the output register; the divider waits behind it.

module centre_band_focus_sharpness #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Pixel input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] pixel
  input  logic                              in_tuser,   // [0] start_of_frame
  // Result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // [15:0] sharpness
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [cbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbfs_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int DIM_W = $clog2(MAX_DIMENSION);
  localparam int SW    = 2 * DIM_W + cbfs_pkg::GREEN_W;
  localparam int PCW   = 2 * DIM_W;

  logic [cbfs_pkg::CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [cbfs_pkg::CFG_W-1:0] frame_height_r, frame_height_nxt;

  logic               q_push, q_pop, q_full, q_empty;
  logic [SW-1:0]      q_sum;
  logic [PCW-1:0]     q_pairs;
  logic [SW+PCW-1:0]  q_rdata;

  // Register writes: take the word whenever the enable is high
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        cbfs_pkg::CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        cbfs_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        default: begin
          frame_width_nxt  = frame_width_r;
          frame_height_nxt = frame_height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cbfs_pkg::FRAME_WIDTH_RST;
      frame_height_r <= cbfs_pkg::FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // Front: count positions, test the window, accumulate the gradient
  cbfs_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_sum        (q_sum),
    .q_pairs      (q_pairs)
  );

  // Per-frame totals: pair count in the upper bits, gradient sum below
  cbfs_fifo #(
    .DATA_W (SW + PCW),
    .DEPTH  (2)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({q_pairs, q_sum}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: scale, divide, hold the result for the consumer
  cbfs_back #(
    .SW  (SW),
    .PCW (PCW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: verif/tb_centre_band_focus_sharpness.sv
// Self-checking testbench for the centre-band focus sharpness block.
`timescale 1ns / 1ps

module tb_centre_band_focus_sharpness;

  // Settle this long after the last sharpness word before touching the registers.
  localparam int DRAIN_CYCLES  = 64;
  // Long receiver hold-off used once to back the block up into in_tready.
  localparam int LONG_HOLD     = 400;
  localparam int RAND_PIXELS   = 600;
  localparam int MAX_DIM       = 4096;
  localparam longint TIMEOUT_NS = 30_000_000;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;
  // How a directed row is checked: no word, a typed value, or the predictor.
  typedef enum logic [1:0] {CHK_NONE, CHK_VALUE, CHK_MODEL} check_t;
  typedef enum logic [1:0] {PX_NOISE, PX_EDGES, PX_FLAT} px_style_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_ALT} rx_mode_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [15:0]                      pixel;
    logic                             sof;
    check_t                           chk;
    logic [15:0]                      value;
    logic [cbfs_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [cbfs_pkg::CFG_W-1:0]       reg_val;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata = '0;   // [15:0] pixel
  logic                           in_tuser = 1'b0; // [0] start_of_frame
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [15:0]                    out_tdata;       // [15:0] sharpness
  logic                           cfg_wr_en = 1'b0;
  logic [cbfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbfs_pkg::CFG_W-1:0]     cfg_wdata = '0;

  centre_band_focus_sharpness dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Focus predictor: own copy of registers and frame state
  // ---------------------------------------------------------------------------
  logic [cbfs_pkg::CFG_W-1:0] width_reg  = cbfs_pkg::FRAME_WIDTH_RST;
  logic [cbfs_pkg::CFG_W-1:0] height_reg = cbfs_pkg::FRAME_HEIGHT_RST;
  bit [5:0]         last_green;
  bit [11:0]        col_pos;
  bit [11:0]        row_pos;
  bit [29:0]        grad_total;
  bit [23:0]        pair_total;

  logic [15:0]      sharpness_q[$];
  int               errors;
  int               results_seen;
  int               pixels_sent;
  int               cfg_writes;
  logic             long_hold = 1'b0;
  logic [15:0]      wanted;

  // A register of 0 acts as 1; anything past the maximum is clamped.
  function automatic int unsigned eff_dim(logic [cbfs_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void clear_frame_totals();
    col_pos    = '0;
    row_pos    = '0;
    grad_total = '0;
    pair_total = '0;
  endfunction

  // Advance the frame state by one pixel; return 1 with the sharpness word
  // when this pixel closes the frame.
  function automatic bit focus_advance(logic [15:0] pix, logic sof,
                                       output logic [15:0] sharp);
    int unsigned     w, h, x0, x1, y0, y1;
    bit [5:0]        g, d;
    longint unsigned num;
    w  = eff_dim(width_reg);
    h  = eff_dim(height_reg);
    x0 = w / 8;
    x1 = w - w / 8;
    y0 = h * 5 / 16;
    y1 = h * 11 / 16;
    g  = pix[cbfs_pkg::GREEN_LSB +: cbfs_pkg::GREEN_W];
    sharp = '0;
    if (sof) clear_frame_totals();
    // A pair counts only when both pixels sit inside the centre band.
    if (row_pos >= y0 && row_pos < y1 && col_pos > x0 && col_pos < x1) begin
      d = (g >= last_green) ? g - last_green : last_green - g;
      grad_total += d;
      pair_total += 1;
    end
    last_green = g;
    if (col_pos >= w - 1) begin
      if (row_pos >= h - 1) begin
        num = 0;
        if (pair_total != 0) begin
          num = grad_total;
          num = num * 1000 / pair_total;
        end
        if (num > 64'hffff) num = 64'hffff;
        sharp = num[15:0];
        clear_frame_totals();
        return 1'b1;
      end
      col_pos = '0;
      row_pos += 1;
    end else begin
      col_pos += 1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d, wanted %0d (word %0d, t=%0t)",
             what, got, want, results_seen, $time);
    errors++;
  endtask

  // Compare every accepted sharpness word with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (sharpness_q.size() == 0) begin
        report_mismatch("word with nothing pending", out_tdata, 16'd0);
      end else begin
        wanted = sharpness_q.pop_front();
        if (out_tdata !== wanted) report_mismatch("sharpness", out_tdata, wanted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall patterns; one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       mode_left;
    mode_left = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // Hold the output off long enough for the totals queue to fill.
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= $urandom_range(0, 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= mode_left[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  int burst_left;

  // Offer one pixel word, hold it until taken, then predict.
  task automatic push_pixel(logic [15:0] pix, logic sof, check_t chk,
                            logic [15:0] value);
    int          gap;
    bit          has_word;
    logic [15:0] sharp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    has_word = focus_advance(pix, sof, sharp);
    case (chk)
      CHK_MODEL: if (has_word) sharpness_q.push_back(sharp);
      CHK_VALUE: sharpness_q.push_back(value);
      default: ;
    endcase
  endtask

  // Drop valid, let every pending word out, then settle.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sharpness_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cbfs_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbfs_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == cbfs_pkg::CFG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [15:0] make_pixel(px_style_t style, int k, bit [5:0] base);
    logic [15:0] p;
    p = 16'($urandom);
    case (style)
      PX_EDGES: p[cbfs_pkg::GREEN_LSB +: cbfs_pkg::GREEN_W] = k[0] ? 6'h3f : 6'h00;
      PX_FLAT:  p[cbfs_pkg::GREEN_LSB +: cbfs_pkg::GREEN_W] = base;
      default: ;
    endcase
    return p;
  endfunction

  // Send one frame (or the first n pixels of one) with random content.
  task automatic send_frame(int n, bit lead_sof, bit noisy);
    px_style_t style;
    bit [5:0]  base;
    logic      sof;
    style = px_style_t'($urandom_range(0, 2));
    base  = 6'($urandom);
    for (int k = 0; k < n; k++) begin
      sof = (k == 0) ? lead_sof : (noisy && $urandom_range(0, 127) == 0);
      push_pixel(make_pixel(style, k, base), sof, CHK_MODEL, 16'd0);
    end
  endtask

  function automatic logic [cbfs_pkg::CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1, 2:    return 13'($urandom_range(1, 2));
      8:       return 13'($urandom_range(13, 40));
      default: return 13'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic plan_row_t pix_row(logic [15:0] pix, logic sof, check_t chk,
                                        logic [15:0] value);
    return '{ROW_PIX, pix, sof, chk, value, '0, '0};
  endfunction

  function automatic plan_row_t cfg_row(logic [cbfs_pkg::CFG_IDX_W-1:0] idx,
                                        logic [cbfs_pkg::CFG_W-1:0] val);
    return '{ROW_CFG, 16'd0, 1'b0, CHK_NONE, 16'd0, idx, val};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan[29];
    bit        settled;
    int        dir_pixels, big_pixels, rand_start, frame_len, frames, pick;
    logic [cbfs_pkg::CFG_W-1:0] wv, hv;

    // Directed words. Typed values: 1x1 frames have no pairs so read 0, and the
    // 3x2 frame alternates green 0/63/0 on its only window row, the top reading.
    plan = '{
      // still at 1920 x 1080: nothing can close
      pix_row(16'hFFFF, 1'b1, CHK_NONE,  16'd0),
      pix_row(16'h0000, 1'b0, CHK_NONE,  16'd0),
      pix_row(16'h07E0, 1'b0, CHK_NONE,  16'd0),
      // zero registers act as 1x1: every pixel closes a frame with no pairs
      cfg_row(cbfs_pkg::CFG_FRAME_WIDTH,  13'd0),
      cfg_row(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd0),
      pix_row(16'h0000, 1'b0, CHK_VALUE, 16'd0),
      pix_row(16'hFFFF, 1'b1, CHK_VALUE, 16'd0),
      pix_row(16'h8001, 1'b0, CHK_VALUE, 16'd0),
      cfg_row(cbfs_pkg::CFG_FRAME_WIDTH,  13'd3),
      cfg_row(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd2),
      pix_row(16'h0000, 1'b1, CHK_NONE,  16'd0),
      pix_row(16'h07E0, 1'b0, CHK_NONE,  16'd0),
      pix_row(16'h0000, 1'b0, CHK_NONE,  16'd0),
      pix_row(16'hFFFF, 1'b0, CHK_NONE,  16'd0),
      pix_row(16'hF81F, 1'b0, CHK_NONE,  16'd0),
      pix_row(16'h0020, 1'b0, CHK_VALUE, 16'd63000),
      // next frame follows without a start mark
      pix_row(16'h07C0, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h0000, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h03E0, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'hF800, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h001F, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h07E0, 1'b0, CHK_MODEL, 16'd0),
      // leave a frame open, then grow past the maximum while it is open
      pix_row(16'h1234, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'hFEDC, 1'b0, CHK_MODEL, 16'd0),
      cfg_row(cbfs_pkg::CFG_FRAME_WIDTH,  13'd8191),
      cfg_row(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd8191),
      pix_row(16'hA5A5, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h5A5A, 1'b0, CHK_MODEL, 16'd0),
      pix_row(16'h0001, 1'b0, CHK_MODEL, 16'd0)
    };

    last_green = '0;
    clear_frame_totals();
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settled = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!settled) drain_block();
        settled = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        settled = 1'b0;
        push_pixel(plan[i].pixel, plan[i].sof, plan[i].chk, plan[i].value);
      end
    end
    dir_pixels = pixels_sent;

    // One wide, short frame and one narrow, tall frame.
    drain_block();
    write_reg(cbfs_pkg::CFG_FRAME_WIDTH,  13'd96);
    write_reg(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd3);
    send_frame(96 * 3, 1'b1, 1'b0);
    drain_block();
    write_reg(cbfs_pkg::CFG_FRAME_WIDTH,  13'd3);
    write_reg(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd96);
    send_frame(3 * 96, 1'b1, 1'b0);
    big_pixels = pixels_sent - dir_pixels;

    // Back-pressure: 1x1 frames while the receiver holds off, so the totals
    // queue fills and the input stalls.
    drain_block();
    write_reg(cbfs_pkg::CFG_FRAME_WIDTH,  13'd1);
    write_reg(cbfs_pkg::CFG_FRAME_HEIGHT, 13'd1);
    long_hold <= 1'b1;
    send_frame(40, 1'b0, 1'b0);

    // Random phases: mostly whole frames at small sizes, with restarts, cut-short
    // frames and resizes while a frame is open.
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      drain_block();
      if ($urandom_range(0, 19) == 0) begin
        // Jump to large sizes and leave the frame open; the next phase shrinks.
        write_reg(cbfs_pkg::CFG_FRAME_WIDTH,  13'($urandom_range(100, 8191)));
        write_reg(cbfs_pkg::CFG_FRAME_HEIGHT, 13'($urandom_range(100, 8191)));
        send_frame($urandom_range(5, 60), $urandom_range(0, 1), 1'b1);
      end else begin
        wv = pick_dim();
        hv = pick_dim();
        pick = $urandom_range(0, 3);
        if (pick != 1 || eff_dim(width_reg) * eff_dim(height_reg) > 400)
          write_reg(cbfs_pkg::CFG_FRAME_WIDTH, wv);
        if (pick != 0 || eff_dim(width_reg) * eff_dim(height_reg) > 400)
          write_reg(cbfs_pkg::CFG_FRAME_HEIGHT, hv);
        frame_len = eff_dim(width_reg) * eff_dim(height_reg);
        frames = $urandom_range(1, 4);
        repeat (frames) begin
          if ($urandom_range(0, 15) == 0)
            send_frame($urandom_range(1, frame_len), $urandom_range(0, 9) != 0, 1'b1);
          else
            send_frame(frame_len, $urandom_range(0, 9) != 0, 1'b1);
        end
        if ($urandom_range(0, 1) == 1)
          send_frame($urandom_range(0, frame_len - 1), 1'b0, 1'b1);
      end
    end

    drain_block();

    $display("covered %0d pixel words (%0d directed, %0d in wide and tall frames, %0d random)",
             pixels_sent, dir_pixels, big_pixels, pixels_sent - rand_start);
    $display("%0d sharpness words, %0d register writes incl. zero, max and clamped sizes",
             results_seen, cfg_writes);
    if (errors == 0) begin
      $display("tb_centre_band_focus_sharpness: done, clean");
    end else begin
      $display("tb_centre_band_focus_sharpness: done, errors");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d sharpness words pending", sharpness_q.size());
    $display("tb_centre_band_focus_sharpness: done, errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/cbfs_pkg.sv
rtl/cbfs_fifo.sv
rtl/cbfs_front.sv
rtl/cbfs_back.sv
rtl/centre_band_focus_sharpness.sv
verif/tb_centre_band_focus_sharpness.sv
